// ===== rtl/etms_pkg.sv =====
package etms_pkg;

    // Block geometry
    localparam int TEMPLATE_SIZE = 30;
    localparam int IMAGE_WIDTH   = 2048;
    localparam int IMAGE_HEIGHT  = 512;

    localparam int TPL_CELLS = TEMPLATE_SIZE * TEMPLATE_SIZE;
    localparam int ROW_CELLS = TEMPLATE_SIZE * IMAGE_WIDTH;

    // Derived widths
    localparam int TPL_AW = $clog2(TPL_CELLS);
    localparam int ROW_AW = $clog2(ROW_CELLS);
    localparam int SLOT_W = $clog2(TEMPLATE_SIZE);
    localparam int COL_W  = $clog2(IMAGE_WIDTH);
    localparam int ROW_W  = $clog2(IMAGE_HEIGHT + 1);

    // Fixed field widths
    localparam int PIX_W  = 24;
    localparam int CHAN_W = 8;
    localparam int MROW_W = 9;
    localparam int MCOL_W = 11;

    // Item commands
    localparam logic CMD_TEMPLATE = 1'b0;
    localparam logic CMD_IMAGE    = 1'b1;

    typedef logic [PIX_W-1:0] pixel_t;

    // Window scan request from the controller
    typedef struct packed {
        logic              start;
        logic [SLOT_W-1:0] slot;
        logic [COL_W-1:0]  left;
    } scan_req_t;

    // Read addresses from the scan sequencer to the stores
    typedef struct packed {
        logic [TPL_AW-1:0] tpl_addr;
        logic [ROW_AW-1:0] img_addr;
    } scan_rd_t;

    // Scan outcome
    typedef struct packed {
        logic done;
        logic hit;
    } scan_sts_t;

endpackage

// ===== rtl/etms_pixel_if.sv =====
interface etms_pixel_if;
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic [etms_pkg::CHAN_W-1:0]  blue;
    logic [etms_pkg::CHAN_W-1:0]  green;
    logic [etms_pkg::CHAN_W-1:0]  red;
    logic                         last_pixel;

    modport source (output valid, cmd, blue, green, red, last_pixel, input ready);
    modport sink   (input valid, cmd, blue, green, red, last_pixel, output ready);
endinterface

// ===== rtl/etms_result_if.sv =====
interface etms_result_if;
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic [etms_pkg::MROW_W-1:0]  match_row;
    logic [etms_pkg::MCOL_W-1:0]  match_col;

    modport source (output valid, found, match_row, match_col, input ready);
    modport sink   (input valid, found, match_row, match_col, output ready);
endinterface

// ===== rtl/etms_store.sv =====
module etms_store (
    input  logic                          clk,
    input  logic                          tpl_we,
    input  logic [etms_pkg::TPL_AW-1:0]   tpl_waddr,
    input  logic                          row_we,
    input  logic [etms_pkg::ROW_AW-1:0]   row_waddr,
    input  etms_pkg::pixel_t              wdata,
    input  etms_pkg::scan_rd_t            rd,
    output etms_pkg::pixel_t              tpl_q,
    output etms_pkg::pixel_t              img_q
);

    etms_pkg::pixel_t tpl_mem [etms_pkg::TPL_CELLS];
    etms_pkg::pixel_t row_mem [etms_pkg::ROW_CELLS];

    // Template store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (tpl_we)
        begin
            tpl_mem[tpl_waddr] <= wdata;
        end
        tpl_q <= tpl_mem[rd.tpl_addr];
    end

    // Line buffer of the last template-height rows
    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[row_waddr] <= wdata;
        end
        img_q <= row_mem[rd.img_addr];
    end

endmodule

// ===== rtl/etms_scan.sv =====
module etms_scan (
    input  logic                 clk,
    input  logic                 rst_n,
    input  etms_pkg::scan_req_t  req,
    output etms_pkg::scan_rd_t   rd,
    input  etms_pkg::pixel_t     tpl_q,
    input  etms_pkg::pixel_t     img_q,
    output etms_pkg::scan_sts_t  sts
);

    typedef enum logic [1:0] {
        SC_IDLE = 2'b01,
        SC_RUN  = 2'b10
    } scan_state_t;

    scan_state_t                   state_reg, state_next;
    logic                          issue_reg, issue_next;
    logic [etms_pkg::SLOT_W-1:0]   p_reg, p_next;
    logic [etms_pkg::SLOT_W-1:0]   q_reg, q_next;
    logic [etms_pkg::SLOT_W-1:0]   s_reg, s_next;
    logic [etms_pkg::COL_W-1:0]    left_reg, left_next;
    logic [etms_pkg::TPL_AW-1:0]   tpl_addr_reg, tpl_addr_next;
    logic                          cmp_valid_reg, cmp_valid_next;
    logic                          cmp_last_reg, cmp_last_next;

    logic issuing;
    logic last_issue;
    logic q_end;
    logic cmp_en;
    logic pix_eq;

    // Read addresses: template in raster order, image slot rows from the window top
    assign rd.tpl_addr = tpl_addr_reg;
    assign rd.img_addr = etms_pkg::ROW_AW'(s_reg) * etms_pkg::ROW_AW'(etms_pkg::IMAGE_WIDTH)
                       + etms_pkg::ROW_AW'(left_reg) + etms_pkg::ROW_AW'(q_reg);

    assign issuing    = (state_reg == SC_RUN) && issue_reg;
    assign q_end      = (q_reg == etms_pkg::SLOT_W'(etms_pkg::TEMPLATE_SIZE - 1));
    assign last_issue = q_end && (p_reg == etms_pkg::SLOT_W'(etms_pkg::TEMPLATE_SIZE - 1));

    // Shared comparator on the registered read data; stops at first mismatch
    assign cmp_en   = (state_reg == SC_RUN) && cmp_valid_reg;
    assign pix_eq   = (img_q == tpl_q);
    assign sts.done = cmp_en && (!pix_eq || cmp_last_reg);
    assign sts.hit  = cmp_en && pix_eq && cmp_last_reg;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        issue_next     = issue_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        s_next         = s_reg;
        left_next      = left_reg;
        tpl_addr_next  = tpl_addr_reg;
        cmp_valid_next = issuing;
        cmp_last_next  = issuing && last_issue;
        unique case (state_reg)
            SC_IDLE:
            begin
                if (req.start)
                begin
                    state_next    = SC_RUN;
                    issue_next    = 1'b1;
                    p_next        = '0;
                    q_next        = '0;
                    s_next        = req.slot;
                    left_next     = req.left;
                    tpl_addr_next = '0;
                end
            end
            SC_RUN:
            begin
                if (issuing)
                begin
                    if (last_issue)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        tpl_addr_next = tpl_addr_reg + 1'b1;
                        if (q_end)
                        begin
                            q_next = '0;
                            p_next = p_reg + 1'b1;
                            if (s_reg == etms_pkg::SLOT_W'(etms_pkg::TEMPLATE_SIZE - 1))
                            begin
                                s_next = '0;
                            end
                            else
                            begin
                                s_next = s_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            q_next = q_reg + 1'b1;
                        end
                    end
                end
                if (sts.done)
                begin
                    state_next = SC_IDLE;
                    issue_next = 1'b0;
                end
            end
            default:
            begin
                state_next = SC_IDLE;
                issue_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SC_IDLE;
            issue_reg     <= 1'b0;
            cmp_valid_reg <= 1'b0;
            cmp_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_reg     <= issue_next;
            cmp_valid_reg <= cmp_valid_next;
            cmp_last_reg  <= cmp_last_next;
        end
    end

    // Scan counters
    always_ff @(posedge clk)
    begin
        p_reg        <= p_next;
        q_reg        <= q_next;
        s_reg        <= s_next;
        left_reg     <= left_next;
        tpl_addr_reg <= tpl_addr_next;
    end

`ifndef NO_ASSERTIONS
    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        sts.done |=> (state_reg == SC_IDLE))
        else $error("scan did not return to idle after completing");

    a_tpl_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        issuing |-> (tpl_addr_reg <= etms_pkg::TPL_AW'(etms_pkg::TPL_CELLS - 1)))
        else $error("template address out of range");

    a_hit_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        sts.hit |-> (cmp_last_reg && $past(issue_reg) && !issue_reg))
        else $error("hit reported before the last window pixel");
`endif

endmodule

// ===== rtl/exact_template_match_search.sv =====
// Exact template search. Load the template first with cmd 0 items, one pixel each in
// raster order (TEMPLATE_SIZE squared of them; the load index wraps to start a new
// template). Then stream the frame with cmd 1 items in raster order and mark the final
// pixel with last_pixel. The first window lying wholly inside the image that equals the
// template on all three channels gives one result with found set and its top-left row
// and column; the rest of the frame then gives nothing. A frame that ends without a match
// gives one result with found clear. An image pixel that completes a window starts a scan of
// the window, which ends early when a pixel differs. The scan uses the single 24-bit
// comparator, which gets one template entry and one line-buffer entry per cycle from the
// two memory read ports. A waiting result sits in an output register; it holds up the
// input only when a later item has a result of its own to give before the waiting one
// is taken.
module exact_template_match_search (
    input  logic                clk,
    input  logic                rst_n,
    etms_pixel_if.sink          pixel,
    etms_result_if.source       result
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_FIN  = 3'b100
    } top_state_t;

    top_state_t                    state_reg, state_next;
    logic [etms_pkg::TPL_AW-1:0]   tpl_idx_reg, tpl_idx_next;
    logic [etms_pkg::ROW_W-1:0]    row_reg, row_next;
    logic [etms_pkg::COL_W-1:0]    col_reg, col_next;
    logic [etms_pkg::SLOT_W-1:0]   slot_reg, slot_next;
    logic                          match_done_reg, match_done_next;
    logic                          last_reg, last_next;
    logic                          hit_reg, hit_next;
    logic [etms_pkg::ROW_W-1:0]    top_reg, top_next;
    logic [etms_pkg::COL_W-1:0]    left_reg, left_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          out_found_reg;
    logic [etms_pkg::MROW_W-1:0]   out_row_reg;
    logic [etms_pkg::MCOL_W-1:0]   out_col_reg;

    logic                          accept;
    logic                          is_image;
    logic                          in_frame;
    logic                          img_active;
    logic                          need_scan;
    logic                          tpl_we;
    logic                          row_we;
    logic [etms_pkg::ROW_AW-1:0]   row_waddr;
    logic [etms_pkg::SLOT_W-1:0]   slot_inc;
    logic                          res_needed;
    logic                          stall;
    logic                          out_load;
    etms_pkg::pixel_t              wdata;
    etms_pkg::pixel_t              tpl_q;
    etms_pkg::pixel_t              img_q;
    etms_pkg::scan_req_t           scan_req;
    etms_pkg::scan_rd_t            scan_rd;
    etms_pkg::scan_sts_t           scan_sts;

    // Input side
    assign pixel.ready = (state_reg == ST_IDLE);
    assign accept      = pixel.valid && pixel.ready;
    assign is_image    = (pixel.cmd == etms_pkg::CMD_IMAGE);
    assign wdata       = {pixel.red, pixel.green, pixel.blue};

    assign in_frame   = (row_reg < etms_pkg::ROW_W'(etms_pkg::IMAGE_HEIGHT));
    assign img_active = !match_done_reg && in_frame;
    assign need_scan  = (row_reg >= etms_pkg::ROW_W'(etms_pkg::TEMPLATE_SIZE - 1))
                     && (col_reg >= etms_pkg::COL_W'(etms_pkg::TEMPLATE_SIZE - 1));

    assign tpl_we    = accept && !is_image;
    assign row_we    = accept && is_image && img_active;
    assign row_waddr = etms_pkg::ROW_AW'(slot_reg) * etms_pkg::ROW_AW'(etms_pkg::IMAGE_WIDTH)
                     + etms_pkg::ROW_AW'(col_reg);

    assign slot_inc = (slot_reg == etms_pkg::SLOT_W'(etms_pkg::TEMPLATE_SIZE - 1))
                    ? '0 : slot_reg + 1'b1;

    // Window scan request: the window top row lives in the slot after the current row
    assign scan_req.start = row_we && need_scan;
    assign scan_req.slot  = slot_inc;
    assign scan_req.left  = col_reg - etms_pkg::COL_W'(etms_pkg::TEMPLATE_SIZE - 1);

    // Result decision
    assign res_needed = hit_reg || (last_reg && !match_done_reg);
    assign stall      = res_needed && out_valid_reg && !result.ready;
    assign out_load   = (state_reg == ST_FIN) && res_needed && !stall;

    // Controller
    always_comb
    begin
        state_next      = state_reg;
        tpl_idx_next    = tpl_idx_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        slot_next       = slot_reg;
        match_done_next = match_done_reg;
        last_next       = last_reg;
        hit_next        = hit_reg;
        top_next        = top_reg;
        left_next       = left_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (tpl_we)
                begin
                    if (tpl_idx_reg == etms_pkg::TPL_AW'(etms_pkg::TPL_CELLS - 1))
                    begin
                        tpl_idx_next = '0;
                    end
                    else
                    begin
                        tpl_idx_next = tpl_idx_reg + 1'b1;
                    end
                end
                else if (accept)
                begin
                    last_next = pixel.last_pixel;
                    hit_next  = 1'b0;
                    top_next  = row_reg - etms_pkg::ROW_W'(etms_pkg::TEMPLATE_SIZE - 1);
                    left_next = scan_req.left;
                    state_next = scan_req.start ? ST_SCAN : ST_FIN;
                    // advance the raster position
                    if (in_frame)
                    begin
                        if (col_reg == etms_pkg::COL_W'(etms_pkg::IMAGE_WIDTH - 1))
                        begin
                            col_next  = '0;
                            row_next  = row_reg + 1'b1;
                            slot_next = slot_inc;
                        end
                        else
                        begin
                            col_next = col_reg + 1'b1;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_sts.done)
                begin
                    hit_next   = scan_sts.hit;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!stall)
                begin
                    state_next = ST_IDLE;
                    if (last_reg)
                    begin
                        match_done_next = 1'b0;
                        row_next        = '0;
                        col_next        = '0;
                        slot_next       = '0;
                    end
                    else if (hit_reg)
                    begin
                        match_done_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            tpl_idx_reg    <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            slot_reg       <= '0;
            match_done_reg <= 1'b0;
            last_reg       <= 1'b0;
            hit_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tpl_idx_reg    <= tpl_idx_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            slot_reg       <= slot_next;
            match_done_reg <= match_done_next;
            last_reg       <= last_next;
            hit_reg        <= hit_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Window position and result payload
    always_ff @(posedge clk)
    begin
        top_reg  <= top_next;
        left_reg <= left_next;
        if (out_load)
        begin
            out_found_reg <= hit_reg;
            out_row_reg   <= hit_reg ? etms_pkg::MROW_W'(top_reg) : '0;
            out_col_reg   <= hit_reg ? etms_pkg::MCOL_W'(left_reg) : '0;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.found     = out_found_reg;
    assign result.match_row = out_row_reg;
    assign result.match_col = out_col_reg;

    etms_store u_store (
        .clk       (clk),
        .tpl_we    (tpl_we),
        .tpl_waddr (tpl_idx_reg),
        .row_we    (row_we),
        .row_waddr (row_waddr),
        .wdata     (wdata),
        .rd        (scan_rd),
        .tpl_q     (tpl_q),
        .img_q     (img_q)
    );

    etms_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (scan_req),
        .rd    (scan_rd),
        .tpl_q (tpl_q),
        .img_q (img_q),
        .sts   (scan_sts)
    );

`ifndef NO_ASSERTIONS
    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        scan_req.start |=> (state_reg == ST_SCAN))
        else $error("window scan started without entering the scan state");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || result.ready))
        else $error("result register overwritten while still held");

    a_hit_sets_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && hit_reg && !last_reg) |=> match_done_reg)
        else $error("match reported but search not stopped");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= etms_pkg::ROW_W'(etms_pkg::IMAGE_HEIGHT))
        else $error("row counter beyond frame height");
`endif

endmodule
